// ----- design/cfa_pkg.sv -----
// shared types and constants for the contiguous fit allocator
// no dependencies; imported by cfa_ctrl, cfa_dpath and the top level
package cfa_pkg;

  // field widths of a request beat and a result beat
  localparam int unsigned OP_W    = 2;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned POL_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned START_W = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

  // fit policies
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, rewind scan state
    logic scan;       // issue one map read, advance read address
    logic close;      // close the run that reaches the end of the map
    logic clear;      // write zero at the write pointer, advance it
    logic fill_init;  // point the write pointer at the chosen run
    logic fill;       // write owner at the write pointer, advance it
    logic res_load;   // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_last;    // read address is the last cell
    logic ptr_end;    // write pointer is the last cell
    logic ptr_full;   // write pointer is past the last cell
    logic fill_last;  // this fill write is the final one
    logic do_scan;    // request needs a map scan
    logic is_alloc;
    logic is_compact;
    logic found;      // a fitting run was picked
  } sts_t;

endpackage

// ----- design/cfa_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module cfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/cfa_ctrl.sv -----
// sequencing state machine of the allocator: clear pass, scan, fill, result
// depends on cfa_pkg
module cfa_ctrl
  import cfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_PREP,
    S_FILL,
    S_TAIL,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.ptr_end) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = sts_i.do_scan ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.rd_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        // last read beat is processed here
        if (sts_i.is_alloc) begin
          state_d = S_EVAL;
        end else if (sts_i.is_compact) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_RESP;
        end
      end
      S_EVAL: begin
        cmd_o.close = 1'b1;
        state_d     = S_PREP;
      end
      S_PREP: begin
        if (sts_i.found) begin
          cmd_o.fill_init = 1'b1;
          state_d         = S_FILL;
        end else begin
          state_d = S_RESP;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) state_d = S_RESP;
      end
      S_TAIL: begin
        if (sts_i.ptr_full) begin
          state_d = S_RESP;
        end else begin
          cmd_o.clear = 1'b1;
          if (sts_i.ptr_end) state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/cfa_dpath.sv -----
// allocator datapath: owner map ram, scan pipeline, run tracking, result register
// depends on cfa_pkg and cfa_ram
module cfa_dpath
  import cfa_pkg::*;
#(
  parameter int unsigned CELLS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [OWNER_W-1:0] owner_i,
  input  logic [LEN_W-1:0]   length_i,
  input  logic [POL_W-1:0]   fit_policy_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [START_W-1:0] start_cell_o
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned CW = $clog2(CELLS + 1);
  localparam int unsigned SW = (CW > LEN_W) ? CW : LEN_W;
  localparam int unsigned XW = (AW > START_W) ? AW : START_W;

  // request
  logic [OP_W-1:0]    op_q;
  logic [OWNER_W-1:0] owner_q;
  logic [LEN_W-1:0]   len_q;
  logic [POL_W-1:0]   pol_q;

  // scan pipeline
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          dv_q;
  logic [AW-1:0] d_idx_q;
  logic [OWNER_W-1:0] rdata;

  // run tracking
  logic [AW-1:0] run_start_q, run_start_d;
  logic [CW-1:0] run_size_q, run_size_d;
  logic [AW-1:0] pick_start_q, pick_start_d;
  logic [CW-1:0] pick_size_q, pick_size_d;
  logic          found_q, found_d;

  // write side
  logic [CW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [OWNER_W-1:0] wdata;

  // result
  logic [STAT_W-1:0]  status_q, status_d;
  logic [START_W-1:0] start_q, start_d;

  logic is_alloc, is_free, is_compact, pol_ok, len_ok;
  logic cell_free, close_now, qualify, take;
  logic beat_free_we, beat_cmp_we;
  logic [XW-1:0] start_ext;

  assign is_alloc   = (op_q == OP_ALLOC);
  assign is_free    = (op_q == OP_FREE);
  assign is_compact = (op_q == OP_COMPACT);
  assign pol_ok     = (pol_q == POL_FIRST) || (pol_q == POL_BEST) || (pol_q == POL_WORST);
  assign len_ok     = (len_q != '0);

  assign cell_free    = (rdata == '0);
  assign beat_free_we = dv_q && is_free && (rdata == owner_q);
  assign beat_cmp_we  = dv_q && is_compact && !cell_free;

  cfa_ram #(
    .WIDTH (OWNER_W),
    .DEPTH (CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  // write port: pointer-driven sweeps or scan beats, never both at once
  always_comb begin
    we    = cmd_i.clear || cmd_i.fill || beat_free_we || beat_cmp_we;
    waddr = beat_free_we ? d_idx_q : wr_ptr_q[AW-1:0];
    if (cmd_i.fill) begin
      wdata = owner_q;
    end else if (beat_cmp_we) begin
      wdata = rdata;
    end else begin
      wdata = '0;
    end
  end

  // run closing and fit selection
  assign close_now = (dv_q && is_alloc && !cell_free) || cmd_i.close;
  assign qualify   = (run_size_q != '0) && (SW'(run_size_q) >= SW'(len_q));
  assign take      = !found_q
                  || ((pol_q == POL_BEST)  && (run_size_q < pick_size_q))
                  || ((pol_q == POL_WORST) && (run_size_q > pick_size_q));

  always_comb begin
    rd_addr_d    = rd_addr_q;
    run_start_d  = run_start_q;
    run_size_d   = run_size_q;
    pick_start_d = pick_start_q;
    pick_size_d  = pick_size_q;
    found_d      = found_q;
    wr_ptr_d     = wr_ptr_q;
    rem_d        = rem_q;

    if (cmd_i.load) begin
      rd_addr_d  = '0;
      run_size_d = '0;
      found_d    = 1'b0;
      wr_ptr_d   = '0;
    end else begin
      if (cmd_i.scan) rd_addr_d = rd_addr_q + AW'(1);
      if (close_now) begin
        if (qualify && take) begin
          found_d      = 1'b1;
          pick_start_d = run_start_q;
          pick_size_d  = run_size_q;
        end
        run_size_d = '0;
      end else if (dv_q && is_alloc) begin
        if (run_size_q == '0) run_start_d = d_idx_q;
        run_size_d = run_size_q + CW'(1);
      end
      if (cmd_i.fill_init) begin
        wr_ptr_d = CW'(pick_start_q);
        rem_d    = len_q;
      end else if (cmd_i.clear || beat_cmp_we) begin
        wr_ptr_d = wr_ptr_q + CW'(1);
      end else if (cmd_i.fill) begin
        wr_ptr_d = wr_ptr_q + CW'(1);
        rem_d    = rem_q - LEN_W'(1);
      end
    end
  end

  // result
  assign start_ext = XW'(pick_start_q);
  always_comb begin
    status_d = ST_DONE;
    start_d  = '0;
    if (is_alloc) begin
      if (!pol_ok) begin
        status_d = ST_BADPOL;
      end else if (!len_ok || !found_q) begin
        status_d = ST_NOFIT;
      end else begin
        start_d = start_ext[START_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q  <= '0;
      dv_q       <= 1'b0;
      run_size_q <= '0;
      found_q    <= 1'b0;
      wr_ptr_q   <= '0;
    end else begin
      rd_addr_q  <= rd_addr_d;
      dv_q       <= cmd_i.scan;
      run_size_q <= run_size_d;
      found_q    <= found_d;
      wr_ptr_q   <= wr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_idx_q      <= rd_addr_q;
    run_start_q  <= run_start_d;
    pick_start_q <= pick_start_d;
    pick_size_q  <= pick_size_d;
    rem_q        <= rem_d;
    if (cmd_i.load) begin
      op_q    <= operation_i;
      owner_q <= owner_i;
      len_q   <= length_i;
      pol_q   <= fit_policy_i;
    end
    if (cmd_i.res_load) begin
      status_q <= status_d;
      start_q  <= start_d;
    end
  end

  assign sts_o.rd_last    = (rd_addr_q == AW'(CELLS - 1));
  assign sts_o.ptr_end    = (wr_ptr_q == CW'(CELLS - 1));
  assign sts_o.ptr_full   = (wr_ptr_q == CW'(CELLS));
  assign sts_o.fill_last  = (rem_q == LEN_W'(1)) || (wr_ptr_q == CW'(CELLS - 1));
  assign sts_o.do_scan    = is_free || is_compact || (is_alloc && pol_ok && len_ok);
  assign sts_o.is_alloc   = is_alloc;
  assign sts_o.is_compact = is_compact;
  assign sts_o.found      = found_q;

  assign status_o     = status_q;
  assign start_cell_o = start_q;

endmodule

// ----- design/contiguous_fit_allocator_unit.sv -----
// top level of the contiguous fit allocator: stream ports, controller, datapath
// depends on cfa_pkg, cfa_ctrl, cfa_dpath (and cfa_ram through the datapath)
//
// The unit keeps an owner map of CELLS cells (8-bit owner id, 0 = free) in a
// single ram and serves one request at a time. Allocate picks a free run of at
// least length cells by first, best or worst fit (ties to the earliest run) and
// writes the owner into its first cells; free clears all cells of an owner;
// compact packs owned cells to the front in order. Every request gives exactly
// one result beat. After reset the unit runs a clearing pass over the map and
// accepts no request until it ends. The scan reads one cell per cycle through
// the map ram read port. Free, compact and a well-formed allocate scan the
// whole map; an allocate with a bad policy or zero length or an unknown
// operation 3 skips the scan. The result sits in an output register, so a new
// request is taken while the previous result waits; a request only stalls at
// its own result for as long as the previous result beat is still held by
// m_axis_tready.
module contiguous_fit_allocator_unit
  import cfa_pkg::*;
#(
  parameter int unsigned CELLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // owner[7:0], length[14:8], fit_policy[16:15], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  // result beat
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // start_cell[5:0], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  cmd_t cmd;
  sts_t sts;

  logic [STAT_W-1:0]  status;
  logic [START_W-1:0] start_cell;

  // sequencing: clear pass, scan, run selection, fill / tail zeroing, result
  cfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // owner map, scan pipeline and result register
  cfa_dpath #(
    .CELLS (CELLS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (s_axis_tuser),
    .owner_i      (s_axis_tdata[7:0]),
    .length_i     (s_axis_tdata[14:8]),
    .fit_policy_i (s_axis_tdata[16:15]),
    .status_o     (status),
    .start_cell_o (start_cell)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {2'b00, start_cell};

endmodule

// ----- test/alloc_check_pkg.sv -----
`timescale 1ns / 100ps
// result scoreboard for the contiguous fit allocator testbench: holds a copy of
// the owner map, works out the result of each accepted request and checks results
// depends on cfa_pkg for field widths, operation, policy and status codes
package alloc_check_pkg;
  import cfa_pkg::*;

  localparam int unsigned MAP_CELLS = 64;

  // codes with no name in the design package
  localparam logic [POL_W-1:0] POL_INVALID = 2'd3;
  localparam logic [OP_W-1:0]  OP_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [START_W-1:0] start_cell;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [OWNER_W-1:0] owner_map [MAP_CELLS];
    alloc_result_t      expected_grants [$];
    int unsigned        mismatches;

    function new();
      foreach (owner_map[c]) owner_map[c] = '0;
      mismatches = 0;
    endfunction

    // walk the map once, closing runs at every owned cell and at the end
    function bit find_fit(input logic [LEN_W-1:0] len, input logic [POL_W-1:0] pol,
                          output int unsigned run_at);
      bit          found;
      bit          is_free;
      bit          take;
      int unsigned pick_at;
      int unsigned pick_size;
      int unsigned cur_at;
      int unsigned cur_size;
      int unsigned c;
      found     = 1'b0;
      pick_at   = 0;
      pick_size = 0;
      cur_at    = 0;
      cur_size  = 0;
      for (c = 0; c <= MAP_CELLS; c++) begin
        is_free = 1'b0;
        if (c < MAP_CELLS) is_free = (owner_map[c] == '0);
        if (is_free) begin
          if (cur_size == 0) cur_at = c;
          cur_size++;
        end else begin
          if (cur_size != 0 && cur_size >= len) begin
            if (!found) take = 1'b1;
            else if (pol == POL_BEST) take = (cur_size < pick_size);
            else if (pol == POL_WORST) take = (cur_size > pick_size);
            else take = 1'b0;
            if (take) begin
              found     = 1'b1;
              pick_at   = cur_at;
              pick_size = cur_size;
            end
            if (found && pol == POL_FIRST) break;
          end
          cur_size = 0;
        end
      end
      run_at = pick_at;
      return found;
    endfunction

    // update the map for one accepted request and queue its result
    function void note_request(input logic [OP_W-1:0] op, input logic [OWNER_W-1:0] owner,
                               input logic [LEN_W-1:0] len, input logic [POL_W-1:0] pol);
      alloc_result_t grant;
      int unsigned   run_at;
      int unsigned   c;
      int unsigned   w;
      grant.status = ST_DONE;
      run_at       = 0;
      case (op)
        OP_ALLOC: begin
          if (pol != POL_FIRST && pol != POL_BEST && pol != POL_WORST) begin
            grant.status = ST_BADPOL;
          end else if (len == 0 || !find_fit(len, pol, run_at)) begin
            grant.status = ST_NOFIT;
            run_at       = 0;
          end else begin
            for (c = 0; c < len && run_at + c < MAP_CELLS; c++)
              owner_map[run_at + c] = owner;
          end
        end
        OP_FREE: begin
          for (c = 0; c < MAP_CELLS; c++)
            if (owner_map[c] == owner) owner_map[c] = '0;
        end
        OP_COMPACT: begin
          w = 0;
          for (c = 0; c < MAP_CELLS; c++) begin
            if (owner_map[c] != '0) begin
              owner_map[w] = owner_map[c];
              w++;
            end
          end
          for (; w < MAP_CELLS; w++) owner_map[w] = '0;
        end
        default: ;
      endcase
      grant.start_cell = run_at[START_W-1:0];
      expected_grants.push_back(grant);
    endfunction

    function void count_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_result(input logic [STAT_W-1:0] status,
                               input logic [START_W-1:0] start_cell);
      alloc_result_t want;
      if (expected_grants.size() == 0) begin
        count_mismatch($sformatf("unexpected result beat status %0d start %0d",
                                 status, start_cell));
        return;
      end
      want = expected_grants.pop_front();
      if (status !== want.status)
        count_mismatch($sformatf("status expected %0d got %0d", want.status, status));
      if (start_cell !== want.start_cell)
        count_mismatch($sformatf("start_cell expected %0d got %0d",
                                 want.start_cell, start_cell));
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction
  endclass

endpackage

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// top of the contiguous fit allocator testbench: clock, reset, request driver,
// result sink with stall patterns, directed and random request sequences
// depends on cfa_pkg, alloc_check_pkg and contiguous_fit_allocator_unit
module testbench;
  import cfa_pkg::*;
  import alloc_check_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1200;
  localparam int unsigned DRAIN_CYCLES    = 160;     // longest request plus margin
  localparam int unsigned WATCHDOG_CYCLES = 800_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // owner[7:0], length[14:8], fit_policy[16:15], zero pad
  logic [1:0]  s_axis_tuser  = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // start_cell[5:0], zero pad
  logic [1:0]  m_axis_tuser;         // status[1:0]

  alloc_scoreboard board;

  // sender burst state
  int unsigned burst_left = 1;

  // receiver stall pattern state
  int unsigned sink_style      = 0;
  int unsigned sink_phase_left = 0;
  int unsigned sink_hold_left  = 0;

  always #6 clk_i = ~clk_i;

  contiguous_fit_allocator_unit #(
    .CELLS(MAP_CELLS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // one request beat; waits out the clearing pass and any busy period via tready
  task automatic send_request(input logic [OP_W-1:0] op, input logic [OWNER_W-1:0] owner,
                              input logic [LEN_W-1:0] len, input logic [POL_W-1:0] pol);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, pol, len, owner};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(op, owner, len, pol);
    burst_left--;
    if (burst_left == 0) begin
      // long bursts now and then give stretches with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // corner cases first: extremes, every policy, end-of-map runs, bad inputs
  task automatic run_directed();
    send_request(OP_ALLOC, 8'd1, 7'd1, POL_FIRST);
    send_request(OP_ALLOC, 8'd255, 7'd64, POL_FIRST);    // one cell short
    send_request(OP_ALLOC, 8'd2, 7'd63, POL_BEST);       // run reaches last cell
    send_request(OP_ALLOC, 8'd3, 7'd1, POL_WORST);       // map full
    send_request(OP_FREE, 8'd1, 7'd0, POL_FIRST);
    send_request(OP_COMPACT, 8'd0, 7'd0, POL_FIRST);
    send_request(OP_FREE, 8'd2, 7'd127, POL_INVALID);    // ignored fields set
    send_request(OP_ALLOC, 8'd255, 7'd64, POL_WORST);    // whole map
    send_request(OP_FREE, 8'd255, 7'd0, POL_FIRST);
    send_request(OP_ALLOC, 8'd5, 7'd0, POL_FIRST);       // zero length
    send_request(OP_ALLOC, 8'd5, 7'd127, POL_BEST);      // above map size
    send_request(OP_ALLOC, 8'd5, 7'd65, POL_WORST);
    send_request(OP_ALLOC, 8'd5, 7'd5, POL_INVALID);     // bad policy
    send_request(OP_ALLOC, 8'd5, 7'd0, POL_INVALID);
    send_request(OP_UNKNOWN, 8'd255, 7'd127, POL_INVALID);
    // carve holes of different sizes, then pick by each policy
    send_request(OP_ALLOC, 8'd10, 7'd4, POL_FIRST);
    send_request(OP_ALLOC, 8'd11, 7'd6, POL_FIRST);
    send_request(OP_ALLOC, 8'd12, 7'd2, POL_FIRST);
    send_request(OP_ALLOC, 8'd13, 7'd8, POL_FIRST);
    send_request(OP_FREE, 8'd11, 7'd0, POL_FIRST);
    send_request(OP_ALLOC, 8'd14, 7'd3, POL_BEST);
    send_request(OP_ALLOC, 8'd15, 7'd3, POL_WORST);
    send_request(OP_ALLOC, 8'd16, 7'd2, POL_FIRST);
    send_request(OP_ALLOC, 8'd0, 7'd5, POL_FIRST);       // owner zero leaves cells free
    send_request(OP_FREE, 8'd0, 7'd0, POL_FIRST);
    send_request(OP_COMPACT, 8'd170, 7'd85, POL_INVALID);
  endtask

  // mostly well-formed alloc/free traffic over a small owner pool so that
  // frees hit and the map fragments; the rest is compaction and bad requests
  task automatic run_random();
    int unsigned          issued;
    int unsigned          pick;
    logic [OP_W-1:0]      op;
    logic [OWNER_W-1:0]   owner;
    logic [LEN_W-1:0]     len;
    logic [POL_W-1:0]     pol;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 99);
      owner = ($urandom_range(0, 9) == 0) ? OWNER_W'($urandom_range(0, 255))
                                          : OWNER_W'($urandom_range(1, 20));
      len   = LEN_W'($urandom_range(0, 127));
      pol   = POL_W'($urandom_range(0, 3));
      if (pick < 58) begin
        op  = OP_ALLOC;
        pol = POL_W'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
          0, 1:    len = LEN_W'($urandom_range(9, 24));
          2:       len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(65, 127))
                                                      : LEN_W'($urandom_range(25, 64));
          default: len = LEN_W'($urandom_range(1, 8));
        endcase
      end else if (pick < 88) begin
        op = OP_FREE;
      end else if (pick < 93) begin
        op = OP_COMPACT;
      end else if (pick < 96) begin
        op  = OP_ALLOC;
        pol = POL_INVALID;
      end else if (pick < 98) begin
        op  = OP_ALLOC;
        len = '0;
      end else begin
        op = OP_UNKNOWN;
      end
      send_request(op, owner, len, pol);
      if (op != OP_UNKNOWN) issued++;
    end
  endtask

  // result sink: the stall style is picked anew at random when each phase ends
  always @(negedge clk_i) begin
    if (sink_phase_left == 0) begin
      sink_style      <= $urandom_range(0, 3);
      sink_phase_left <= $urandom_range(50, 400);
    end else begin
      sink_phase_left <= sink_phase_left - 1;
    end
    case (sink_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        // alternating runs of ready and stall
        if (sink_hold_left == 0) begin
          m_axis_tready  <= ~m_axis_tready;
          sink_hold_left <= $urandom_range(1, 12);
        end else begin
          sink_hold_left <= sink_hold_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata[START_W-1:0]);
  end

  initial begin
    repeat (WATCHDOG_CYCLES) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    board = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cfa_pkg.sv
design/cfa_ram.sv
design/cfa_ctrl.sv
design/cfa_dpath.sv
design/contiguous_fit_allocator_unit.sv
test/alloc_check_pkg.sv
test/testbench.sv
